// ===== sv/perlin_noise_3d_sampler_unit_defines.svh =====
// Assertion macros shared by the noise sampler RTL.
`ifndef PERLIN_NOISE_3D_SAMPLER_UNIT_DEFINES_SVH
`define PERLIN_NOISE_3D_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PN3D_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pn3d check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define PN3D_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pn3d check failed");

`endif

// ===== sv/pn3d_pkg.sv =====
// Shared constants, types and helper functions of the noise sampler.
package pn3d_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int PERM_ENTRIES = 256;
  localparam int PERM_W       = $clog2(PERM_ENTRIES);
  localparam int BYTE_W       = 8;
  localparam int COORD_W      = 48;
  localparam int CELL_W       = 8;
  localparam int LOW_W        = FRAC_BITS + CELL_W;
  localparam int FADE_W       = FRAC_BITS + 1;
  localparam int COMP_W       = FRAC_BITS + 1;
  localparam int VAL_W        = 20;
  localparam int NUM_AXES     = 3;
  localparam int NUM_RAMS     = 7;
  localparam int NUM_CORNERS  = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int IN_DATA_W    = 2 * BYTE_W + NUM_AXES * COORD_W;
  localparam int OUT_DATA_W   = ((VAL_W + 7) / 8) * 8;
  localparam int POS_LSB      = 2 * BYTE_W;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_OFFSET_Z = 2'd2
  } cfg_reg_e;

  // Item bookkeeping that travels down the table lookup stages.
  typedef struct packed {
    logic              vld;
    opcode_e           op;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] val;
  } item_ctl_t;

  // Table address of base + offset (+1), wrapped to the table size.
  function automatic logic [PERM_W-1:0] perm_addr(input logic [BYTE_W-1:0] base,
                                                  input logic [BYTE_W-1:0] add,
                                                  input logic inc);
    logic [BYTE_W+1:0] s;
    s = (BYTE_W+2)'(base) + (BYTE_W+2)'(add) + (BYTE_W+2)'(inc);
    return s[PERM_W-1:0];
  endfunction

  // A load outside the table is dropped.
  function automatic logic idx_ok(input logic [BYTE_W-1:0] idx);
    return ({1'b0, idx} < (BYTE_W+1)'(PERM_ENTRIES));
  endfunction

  // Gradient dot product selected by the low four hash bits.
  function automatic logic signed [VAL_W-1:0] grad(input logic [BYTE_W-1:0] hash,
                                                   input logic signed [COMP_W-1:0] x,
                                                   input logic signed [COMP_W-1:0] y,
                                                   input logic signed [COMP_W-1:0] z);
    logic [3:0] h;
    logic signed [COMP_W-1:0] ga;
    logic signed [COMP_W-1:0] gb;
    logic signed [VAL_W-1:0] ea;
    logic signed [VAL_W-1:0] eb;
    h  = hash[3:0];
    ga = h[3] ? y : x;
    if (h[3:2] == 2'b00) begin
      gb = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      gb = x;
    end else begin
      gb = z;
    end
    ea = VAL_W'(ga);
    eb = VAL_W'(gb);
    if (h[0]) ea = -ea;
    if (h[1]) eb = -eb;
    return ea + eb;
  endfunction

endpackage

// ===== sv/perlin_noise_3d_sampler_unit.sv =====
// Top level of the pipelined 3D gradient noise sampler.
//
//  Port group   Direction  Transfer on             Content
//  s_axis_*     in         tvalid && tready        load or sample item
//  m_axis_*     out        tvalid && tready        noise value
//  cfg_*        in         cfg_we_i                offset register write
//
// One item per cycle while the output is not stalled; a sample passes
// the three chained table lookups (one RAM read stage each) and the
// three blend levels (two stages each) on its way to the output register.
// Reset clears all valid bits and the offsets; the table is not cleared.
// A stall on the output freezes every stage, so nothing is lost or repeated.
`include "perlin_noise_3d_sampler_unit_defines.svh"

module perlin_noise_3d_sampler_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // entry_index, entry_value, pos_x, pos_y, pos_z
  input  logic [pn3d_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // opcode
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // noise_value, zero padded
  output logic [pn3d_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  input  logic                                 cfg_we_i,
  input  logic [pn3d_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pn3d_pkg::COORD_W-1:0]         cfg_wdata_i
);

  localparam int F  = pn3d_pkg::FRAC_BITS;
  localparam int CW = pn3d_pkg::COORD_W;
  localparam int LW = pn3d_pkg::LOW_W;
  localparam int BW = pn3d_pkg::BYTE_W;
  localparam int PW = pn3d_pkg::PERM_W;
  localparam int VW = pn3d_pkg::VAL_W;

  logic adv;

  // Offset registers.
  logic [CW-1:0] off_q [pn3d_pkg::NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (pn3d_pkg::cfg_reg_e'(cfg_idx_i))
        pn3d_pkg::CFG_OFFSET_X: off_q[0] <= cfg_wdata_i;
        pn3d_pkg::CFG_OFFSET_Y: off_q[1] <= cfg_wdata_i;
        pn3d_pkg::CFG_OFFSET_Z: off_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free.
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Stage zero: saturating offset add, keep cell and fraction bits.
  logic [CW:0]   sum   [pn3d_pkg::NUM_AXES];
  logic [LW-1:0] low_d [pn3d_pkg::NUM_AXES];

  always_comb begin
    for (int k = 0; k < pn3d_pkg::NUM_AXES; k++) begin
      sum[k] = {s_axis_tdata_i[pn3d_pkg::POS_LSB + CW*k + CW-1],
                s_axis_tdata_i[pn3d_pkg::POS_LSB + CW*k +: CW]}
             + {off_q[k][CW-1], off_q[k]};
      low_d[k] = (sum[k][CW] ^ sum[k][CW-1]) ? {LW{~sum[k][CW]}} : sum[k][LW-1:0];
    end
  end

  pn3d_pkg::item_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;
  pn3d_pkg::item_ctl_t s0_ctl;
  logic [LW-1:0] s1_low_q [pn3d_pkg::NUM_AXES];

  assign s0_ctl.vld = s_axis_tvalid_i;
  assign s0_ctl.op  = pn3d_pkg::opcode_e'(s_axis_tuser_i);
  assign s0_ctl.idx = s_axis_tdata_i[BW-1:0];
  assign s0_ctl.val = s_axis_tdata_i[2*BW-1:BW];

  // Control stages of the lookup chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else if (adv) begin
      s1_ctl_q <= s0_ctl;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // Lookup chain payload.
  logic [BW-1:0] s2_cy_q, s2_cz_q, s3_cz_q;
  logic [F-1:0]  s2_frac_q [pn3d_pkg::NUM_AXES];
  logic [F-1:0]  s3_frac_q [pn3d_pkg::NUM_AXES];
  logic [F-1:0]  s4_frac_q [pn3d_pkg::NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_low_q <= low_d;
      s2_cy_q  <= s1_low_q[1][LW-1:F];
      s2_cz_q  <= s1_low_q[2][LW-1:F];
      s3_cz_q  <= s2_cz_q;
      for (int k = 0; k < pn3d_pkg::NUM_AXES; k++) begin
        s2_frac_q[k] <= s1_low_q[k][F-1:0];
        s3_frac_q[k] <= s2_frac_q[k];
        s4_frac_q[k] <= s3_frac_q[k];
      end
    end
  end

  // Table copies: copy 0 for the first lookup, 1-2 for the second, 3-6 for the third.
  // Each copy is written by a load in the stage that reads it, keeping item order.
  logic [PW-1:0] ram_ra [pn3d_pkg::NUM_RAMS];
  logic [PW-1:0] ram_rb [pn3d_pkg::NUM_RAMS];
  logic [BW-1:0] ram_da [pn3d_pkg::NUM_RAMS];
  logic [BW-1:0] ram_db [pn3d_pkg::NUM_RAMS];
  logic          ram_we [pn3d_pkg::NUM_RAMS];
  logic [PW-1:0] ram_wa [pn3d_pkg::NUM_RAMS];
  logic [BW-1:0] ram_wd [pn3d_pkg::NUM_RAMS];
  logic          we1, we2, we3;

  always_comb begin
    we1 = adv && s1_ctl_q.vld && (s1_ctl_q.op == pn3d_pkg::OP_LOAD)
          && pn3d_pkg::idx_ok(s1_ctl_q.idx);
    we2 = adv && s2_ctl_q.vld && (s2_ctl_q.op == pn3d_pkg::OP_LOAD)
          && pn3d_pkg::idx_ok(s2_ctl_q.idx);
    we3 = adv && s3_ctl_q.vld && (s3_ctl_q.op == pn3d_pkg::OP_LOAD)
          && pn3d_pkg::idx_ok(s3_ctl_q.idx);

    ram_we[0] = we1;
    ram_wa[0] = s1_ctl_q.idx[PW-1:0];
    ram_wd[0] = s1_ctl_q.val;
    ram_ra[0] = pn3d_pkg::perm_addr(s1_low_q[0][LW-1:F], '0, 1'b0);
    ram_rb[0] = pn3d_pkg::perm_addr(s1_low_q[0][LW-1:F], '0, 1'b1);

    for (int r = 1; r < 3; r++) begin
      ram_we[r] = we2;
      ram_wa[r] = s2_ctl_q.idx[PW-1:0];
      ram_wd[r] = s2_ctl_q.val;
    end
    ram_ra[1] = pn3d_pkg::perm_addr(ram_da[0], s2_cy_q, 1'b0);
    ram_rb[1] = pn3d_pkg::perm_addr(ram_da[0], s2_cy_q, 1'b1);
    ram_ra[2] = pn3d_pkg::perm_addr(ram_db[0], s2_cy_q, 1'b0);
    ram_rb[2] = pn3d_pkg::perm_addr(ram_db[0], s2_cy_q, 1'b1);

    for (int r = 3; r < pn3d_pkg::NUM_RAMS; r++) begin
      ram_we[r] = we3;
      ram_wa[r] = s3_ctl_q.idx[PW-1:0];
      ram_wd[r] = s3_ctl_q.val;
    end
    // aa, ab, ba, bb in that order.
    ram_ra[3] = pn3d_pkg::perm_addr(ram_da[1], s3_cz_q, 1'b0);
    ram_rb[3] = pn3d_pkg::perm_addr(ram_da[1], s3_cz_q, 1'b1);
    ram_ra[4] = pn3d_pkg::perm_addr(ram_db[1], s3_cz_q, 1'b0);
    ram_rb[4] = pn3d_pkg::perm_addr(ram_db[1], s3_cz_q, 1'b1);
    ram_ra[5] = pn3d_pkg::perm_addr(ram_da[2], s3_cz_q, 1'b0);
    ram_rb[5] = pn3d_pkg::perm_addr(ram_da[2], s3_cz_q, 1'b1);
    ram_ra[6] = pn3d_pkg::perm_addr(ram_db[2], s3_cz_q, 1'b0);
    ram_rb[6] = pn3d_pkg::perm_addr(ram_db[2], s3_cz_q, 1'b1);
  end

  for (genvar r = 0; r < pn3d_pkg::NUM_RAMS; r++) begin : g_ram
    pn3d_ram #(
      .DATA_W(BW),
      .DEPTH (pn3d_pkg::PERM_ENTRIES)
    ) u_ram (
      .clk_i    (clk_i),
      .we_i     (ram_we[r]),
      .waddr_i  (ram_wa[r]),
      .wdata_i  (ram_wd[r]),
      .re_i     (adv),
      .raddr_a_i(ram_ra[r]),
      .raddr_b_i(ram_rb[r]),
      .rdata_a_o(ram_da[r]),
      .rdata_b_o(ram_db[r])
    );
  end

  // Fade curves, lined up with stage four.
  logic [pn3d_pkg::FADE_W-1:0] fade4 [pn3d_pkg::NUM_AXES];

  for (genvar k = 0; k < pn3d_pkg::NUM_AXES; k++) begin : g_fade
    pn3d_fade u_fade (
      .clk_i(clk_i),
      .en_i (adv),
      .t_i  (s1_low_q[k][F-1:0]),
      .f_o  (fade4[k])
    );
  end

  // Stage four: gradients at the eight corners.
  logic signed [pn3d_pkg::COMP_W-1:0] x0, x1, y0, y1, z0, z1;
  logic signed [VW-1:0] grad_d [pn3d_pkg::NUM_CORNERS];

  always_comb begin
    x0 = $signed({1'b0, s4_frac_q[0]});
    x1 = $signed({1'b1, s4_frac_q[0]});
    y0 = $signed({1'b0, s4_frac_q[1]});
    y1 = $signed({1'b1, s4_frac_q[1]});
    z0 = $signed({1'b0, s4_frac_q[2]});
    z1 = $signed({1'b1, s4_frac_q[2]});
    grad_d[0] = pn3d_pkg::grad(ram_da[3], x0, y0, z0);
    grad_d[1] = pn3d_pkg::grad(ram_da[5], x1, y0, z0);
    grad_d[2] = pn3d_pkg::grad(ram_da[4], x0, y1, z0);
    grad_d[3] = pn3d_pkg::grad(ram_da[6], x1, y1, z0);
    grad_d[4] = pn3d_pkg::grad(ram_db[3], x0, y0, z1);
    grad_d[5] = pn3d_pkg::grad(ram_db[5], x1, y0, z1);
    grad_d[6] = pn3d_pkg::grad(ram_db[4], x0, y1, z1);
    grad_d[7] = pn3d_pkg::grad(ram_db[6], x1, y1, z1);
  end

  // Sample valid bits for stages four to eleven.
  logic [11:4] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q[4]    <= s3_ctl_q.vld && (s3_ctl_q.op == pn3d_pkg::OP_SAMPLE);
      vld_q[11:5] <= vld_q[10:4];
    end
  end

  logic signed [VW-1:0]        grad_q [pn3d_pkg::NUM_CORNERS];
  logic [pn3d_pkg::FADE_W-1:0] fx_q;
  logic [pn3d_pkg::FADE_W-1:0] fy_q [3];
  logic [pn3d_pkg::FADE_W-1:0] fz_q [5];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grad_q   <= grad_d;
      fx_q     <= fade4[0];
      fy_q[0]  <= fade4[1];
      fy_q[1]  <= fy_q[0];
      fy_q[2]  <= fy_q[1];
      fz_q[0]  <= fade4[2];
      for (int i = 1; i < 5; i++) begin
        fz_q[i] <= fz_q[i-1];
      end
    end
  end

  // Blend along x, then y, then z.
  logic signed [VW-1:0] lx [4];
  logic signed [VW-1:0] ly [2];
  logic signed [VW-1:0] lz;

  for (genvar i = 0; i < 4; i++) begin : g_lerp_x
    pn3d_lerp u_lerp (
      .clk_i(clk_i),
      .en_i (adv),
      .s_i  (fx_q),
      .a_i  (grad_q[2*i]),
      .b_i  (grad_q[2*i+1]),
      .y_o  (lx[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_lerp_y
    pn3d_lerp u_lerp (
      .clk_i(clk_i),
      .en_i (adv),
      .s_i  (fy_q[2]),
      .a_i  (lx[2*i]),
      .b_i  (lx[2*i+1]),
      .y_o  (ly[i])
    );
  end

  pn3d_lerp u_lerp_z (
    .clk_i(clk_i),
    .en_i (adv),
    .s_i  (fz_q[4]),
    .a_i  (ly[0]),
    .b_i  (ly[1]),
    .y_o  (lz)
  );

  // Output register; the blended value always fits the output range.
  logic          out_vld_q;
  logic [VW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[11];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= lz;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = pn3d_pkg::OUT_DATA_W'(out_data_q);

  `PN3D_ASSERT_NEXT(a_sample_enters, s_axis_tvalid_i && adv && s_axis_tuser_i, s1_ctl_q.vld && (s1_ctl_q.op == pn3d_pkg::OP_SAMPLE))
  `PN3D_ASSERT_NEXT(a_out_follows, adv && vld_q[11], out_vld_q)
  `PN3D_ASSERT_NEXT(a_no_phantom_out, adv && !vld_q[11], !out_vld_q)
  `PN3D_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_q) && $stable(out_data_q))
  `PN3D_ASSERT_IMPL(a_load_writes_once, we1, !(s1_ctl_q.op == pn3d_pkg::OP_SAMPLE))

endmodule

// ===== sv/pn3d_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module pn3d_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads, held while re_i is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/pn3d_fade.sv =====
// Three-stage fade curve 6t^5-15t^4+10t^3 in fixed point.
module pn3d_fade (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pn3d_pkg::FRAC_BITS-1:0] t_i,
  output logic [pn3d_pkg::FADE_W-1:0]    f_o
);

  localparam int F    = pn3d_pkg::FRAC_BITS;
  localparam int Q_W  = F + 4;
  localparam int QS_W = F + 6;

  logic [2*F:0]     sq;
  logic [F:0]       t2_d, t2_q;
  logic [F-1:0]     t1_q;
  logic signed [QS_W-1:0] qs;
  logic [Q_W-1:0]   q_d, q_q;
  logic [2*F+1:0]   cube;
  logic [F:0]       t3_d, t3_q;
  logic [2*F+5:0]   fp;
  logic [F+5:0]     fr;
  logic [F:0]       f_d, f_q;

  // Stage one: t squared, rounded.
  always_comb begin
    sq   = (2*F+1)'(t_i) * (2*F+1)'(t_i) + (2*F+1)'(1 << (F-1));
    t2_d = sq[2*F:F];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q <= t2_d;
      t1_q <= t_i;
    end
  end

  // Stage two: polynomial 6t^2 - 15t + 10 and the rounded cube.
  always_comb begin
    qs = $signed(QS_W'(6) * QS_W'(t2_q) + QS_W'(10 * (1 << F)) - QS_W'(15) * QS_W'(t1_q));
    q_d  = (qs < 0) ? '0 : qs[Q_W-1:0];
    cube = (2*F+2)'(t2_q) * (2*F+2)'(t1_q) + (2*F+2)'(1 << (F-1));
    t3_d = cube[2*F:F];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= q_d;
      t3_q  <= t3_d;
    end
  end

  // Stage three: final product, clamped to one.
  always_comb begin
    fp  = (2*F+6)'(t3_q) * (2*F+6)'(q_q) + (2*F+6)'(1 << (F-1));
    fr  = fp[2*F+5:F];
    f_d = (fr > (F+6)'(1 << F)) ? (F+1)'(1 << F) : fr[F:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
    end
  end

  assign f_o = f_q;

endmodule

// ===== sv/pn3d_lerp.sv =====
// Two-stage linear blend a + round(s * (b - a)).
module pn3d_lerp (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [pn3d_pkg::FADE_W-1:0]       s_i,
  input  logic signed [pn3d_pkg::VAL_W-1:0] a_i,
  input  logic signed [pn3d_pkg::VAL_W-1:0] b_i,
  output logic signed [pn3d_pkg::VAL_W-1:0] y_o
);

  localparam int F      = pn3d_pkg::FRAC_BITS;
  localparam int VW     = pn3d_pkg::VAL_W;
  localparam int PROD_W = pn3d_pkg::FADE_W + VW + 2;

  logic signed [VW:0]       diff;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [VW-1:0]     a_q;
  logic signed [PROD_W-1:0] rsum;
  logic signed [PROD_W-1:0] rsh;
  logic signed [VW-1:0]     y_d, y_q;

  // Stage one: difference times weight.
  always_comb begin
    diff   = (VW+1)'(b_i) - (VW+1)'(a_i);
    prod_d = PROD_W'($signed({1'b0, s_i})) * PROD_W'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  // Stage two: round half up and add the base.
  always_comb begin
    rsum = prod_q + PROD_W'(1 << (F-1));
    rsh  = rsum >>> F;
    y_d  = a_q + rsh[VW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule
